// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, skipped while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== src/cse_pkg.sv =====
// types and constants shared by the cosine similarity engine
`default_nettype none

package cse_pkg;

   // element and accumulator widths
   localparam int ELEM_WIDTH = 16;
   localparam int DOT_W      = 44;
   localparam int SQ_W       = 43;
   localparam int PROD_W     = 2 * SQ_W;
   localparam int ROOT_W     = SQ_W;
   localparam int SIM_W      = 16;

   // step counter for the finishing sequence
   localparam int CNT_W = 6;
   localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(4);
   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);
   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(18);

   // controller states
   typedef enum logic [5:0] {
      ST_ACC  = 6'b000001,
      ST_CAP  = 6'b000010,
      ST_MUL  = 6'b000100,
      ST_SQRT = 6'b001000,
      ST_DIV  = 6'b010000,
      ST_OUT  = 6'b100000
   } cse_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic       cfg_wr;
      logic       load_in;
      logic       capture;
      logic       mul_pp;
      logic       mul_add;
      logic [1:0] mul_sel;
      logic       sqrt_step;
      logic       div_init;
      logic       div_step;
      logic       out_load;
   } cse_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic zero_norm;
   } cse_sts_type;

endpackage

`default_nettype wire

// ===== src/cse_chan.sv =====
// channel interfaces: element pairs in, results out, mode register write
`default_nettype none

interface cse_req_chan;
   logic                                 valid;
   logic                                 ready;
   logic signed [cse_pkg::ELEM_WIDTH-1:0] u_elem;
   logic signed [cse_pkg::ELEM_WIDTH-1:0] v_elem;
   logic                                 last_elem;

   modport source (output valid, u_elem, v_elem, last_elem, input ready);
   modport sink   (input valid, u_elem, v_elem, last_elem, output ready);
endinterface

interface cse_rsp_chan;
   logic                            valid;
   logic                            ready;
   logic signed [cse_pkg::SIM_W-1:0] similarity;
   logic                            status;

   modport source (output valid, similarity, status, input ready);
   modport sink   (input valid, similarity, status, output ready);
endinterface

interface cse_csr_chan;
   logic valid;
   logic ready;
   logic wdata;

   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface

`default_nettype wire

// ===== src/cse_ctrl.sv =====
// controller: accumulate, capture, multiply, square root, divide, output; a zero norm skips to output
`default_nettype none

module cse_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_last,
   output logic                      req_ready,
   input  wire logic                 rsp_ready,
   output logic                      rsp_valid,
   input  wire logic                 csr_valid,
   input  wire cse_pkg::cse_sts_type sts,
   output cse_pkg::cse_cmd_type      cmd
);

   cse_pkg::cse_state_type         state_ff, state_in;
   logic [cse_pkg::CNT_W-1:0]      cnt_ff, cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           req_beat;

   assign req_ready = (state_ff == cse_pkg::ST_ACC);
   assign req_beat  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.cfg_wr = csr_valid;
      unique case (state_ff)
         cse_pkg::ST_ACC: begin
            cmd.load_in = req_beat;
            if (req_beat && req_last) begin
               state_in = cse_pkg::ST_CAP;
            end
         end
         cse_pkg::ST_CAP: begin
            cmd.capture = 1'b1;
            cnt_in      = '0;
            state_in    = cse_pkg::ST_MUL;
         end
         cse_pkg::ST_MUL: begin
            if (cnt_ff == '0 && sts.zero_norm) begin
               state_in = cse_pkg::ST_OUT;
            end else begin
               cmd.mul_pp  = (cnt_ff != cse_pkg::MUL_LAST);
               cmd.mul_add = (cnt_ff != '0);
               cmd.mul_sel = cnt_ff[1:0];
               if (cnt_ff == cse_pkg::MUL_LAST) begin
                  cnt_in   = '0;
                  state_in = cse_pkg::ST_SQRT;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         cse_pkg::ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == cse_pkg::SQRT_LAST) begin
               cnt_in   = '0;
               state_in = cse_pkg::ST_DIV;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         cse_pkg::ST_DIV: begin
            cmd.div_init = (cnt_ff == '0);
            cmd.div_step = (cnt_ff != '0);
            if (cnt_ff == cse_pkg::DIV_LAST) begin
               cnt_in   = '0;
               state_in = cse_pkg::ST_OUT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         cse_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = cse_pkg::ST_ACC;
            end
         end
         default: begin
            state_in = cse_pkg::ST_ACC;
         end
      endcase
   end

   // output beat holding register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cse_pkg::ST_ACC;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/cse_dpath.sv =====
// datapath: multiply-accumulate, norm product, square root, divide, output
`default_nettype none

module cse_dpath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic signed [cse_pkg::ELEM_WIDTH-1:0] u_elem,
   input  wire logic signed [cse_pkg::ELEM_WIDTH-1:0] v_elem,
   input  wire logic                                  csr_wdata,
   input  wire cse_pkg::cse_cmd_type                  cmd,
   output cse_pkg::cse_sts_type                       sts,
   output logic signed [cse_pkg::SIM_W-1:0]           similarity,
   output logic                                       status
);

   localparam int DOT_W  = cse_pkg::DOT_W;
   localparam int SQ_W   = cse_pkg::SQ_W;
   localparam int PROD_W = cse_pkg::PROD_W;
   localparam int ROOT_W = cse_pkg::ROOT_W;
   localparam int HALF_W = (SQ_W + 1) / 2;
   localparam int PP_W   = 2 * HALF_W;
   localparam int REM_W  = ROOT_W + 1;
   localparam int DIV_W  = 62;
   localparam int Q_W    = 18;

   // partial product shift codes
   localparam logic [1:0] SH_NONE = 2'd0;
   localparam logic [1:0] SH_HALF = 2'd1;
   localparam logic [1:0] SH_FULL = 2'd2;

   localparam logic signed [DOT_W-1:0] DOT_MAX = {1'b0, {(DOT_W-1){1'b1}}};
   localparam logic signed [DOT_W-1:0] DOT_MIN = {1'b1, {(DOT_W-1){1'b0}}};

   function automatic logic signed [15:0] elem_value(input logic [15:0] raw,
                                                     input logic       qmode);
      elem_value = qmode ? {{8{raw[7]}}, raw[7:0]} : raw;
   endfunction

   logic                      mode_ff;
   logic signed [15:0]        u_val, v_val;
   logic signed [31:0]        uv_in, uu_full, vv_full;
   logic signed [31:0]        uv_ff;
   logic [30:0]               uu_ff, vv_ff;
   logic                      s1_vld_ff;

   logic signed [DOT_W-1:0]   dot_acc_ff, dot_sat;
   logic [SQ_W-1:0]           u_acc_ff, v_acc_ff, u_sat, v_sat;
   logic [DOT_W:0]            dot_wide;
   logic [SQ_W:0]             u_wide, v_wide;

   logic [DOT_W-1:0]          dot_fin_ff;
   logic [SQ_W-1:0]           u_fin_ff, v_fin_ff;
   logic                      zero_ff;

   logic [HALF_W-1:0]         mul_a, mul_b;
   logic [PP_W-1:0]           pp_in, pp_ff;
   logic [1:0]                pp_sh_in, pp_sh_ff;
   logic [PROD_W-1:0]         pp_shifted;
   logic [PROD_W-1:0]         prod_ff;

   logic [REM_W-1:0]          sq_rem_ff;
   logic [ROOT_W-1:0]         root_ff;
   logic [REM_W+1:0]          sq_rem_in, sq_trial;
   logic                      sq_take;

   logic [DOT_W-1:0]          mag;
   logic [DIV_W-1:0]          div_rem_ff, dsh_ff;
   logic [Q_W-1:0]            q_ff;
   logic                      div_take;

   logic signed [15:0]        sim_in;
   logic                      status_in;
   logic signed [15:0]        sim_ff;
   logic                      status_ff;

   // mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (cmd.cfg_wr) begin
         mode_ff <= csr_wdata;
      end
   end

   // element decode and products
   assign u_val   = elem_value(u_elem, mode_ff);
   assign v_val   = elem_value(v_elem, mode_ff);
   assign uv_in   = u_val * v_val;
   assign uu_full = u_val * u_val;
   assign vv_full = v_val * v_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.load_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         uv_ff <= uv_in;
         uu_ff <= uu_full[30:0];
         vv_ff <= vv_full[30:0];
      end
   end

   // saturating sums
   always_comb begin
      dot_wide = {dot_acc_ff[DOT_W-1], dot_acc_ff} + {{(DOT_W-31){uv_ff[31]}}, uv_ff};
      if (dot_wide[DOT_W] != dot_wide[DOT_W-1]) begin
         dot_sat = dot_wide[DOT_W] ? DOT_MIN : DOT_MAX;
      end else begin
         dot_sat = dot_wide[DOT_W-1:0];
      end
      u_wide = {1'b0, u_acc_ff} + (SQ_W+1)'(uu_ff);
      v_wide = {1'b0, v_acc_ff} + (SQ_W+1)'(vv_ff);
      u_sat  = u_wide[SQ_W] ? {SQ_W{1'b1}} : u_wide[SQ_W-1:0];
      v_sat  = v_wide[SQ_W] ? {SQ_W{1'b1}} : v_wide[SQ_W-1:0];
   end

   // accumulators, cleared when the last pair is captured
   always_ff @(posedge clock) begin
      if (reset) begin
         dot_acc_ff <= '0;
         u_acc_ff   <= '0;
         v_acc_ff   <= '0;
      end else if (cmd.capture) begin
         dot_acc_ff <= '0;
         u_acc_ff   <= '0;
         v_acc_ff   <= '0;
      end else if (s1_vld_ff) begin
         dot_acc_ff <= dot_sat;
         u_acc_ff   <= u_sat;
         v_acc_ff   <= v_sat;
      end
   end

   // finishing operands
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         dot_fin_ff <= dot_sat;
         u_fin_ff   <= u_sat;
         v_fin_ff   <= v_sat;
         zero_ff    <= (u_sat == '0) || (v_sat == '0);
      end
   end

   assign sts.zero_norm = zero_ff;

   // partial product operand select
   always_comb begin
      case (cmd.mul_sel)
         2'd0: begin
            mul_a    = u_fin_ff[HALF_W-1:0];
            mul_b    = v_fin_ff[HALF_W-1:0];
            pp_sh_in = SH_NONE;
         end
         2'd1: begin
            mul_a    = u_fin_ff[HALF_W-1:0];
            mul_b    = HALF_W'(v_fin_ff[SQ_W-1:HALF_W]);
            pp_sh_in = SH_HALF;
         end
         2'd2: begin
            mul_a    = HALF_W'(u_fin_ff[SQ_W-1:HALF_W]);
            mul_b    = v_fin_ff[HALF_W-1:0];
            pp_sh_in = SH_HALF;
         end
         default: begin
            mul_a    = HALF_W'(u_fin_ff[SQ_W-1:HALF_W]);
            mul_b    = HALF_W'(v_fin_ff[SQ_W-1:HALF_W]);
            pp_sh_in = SH_FULL;
         end
      endcase
      pp_in = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_pp) begin
         pp_ff    <= pp_in;
         pp_sh_ff <= pp_sh_in;
      end
   end

   // align the registered partial product
   always_comb begin
      case (pp_sh_ff)
         SH_NONE: pp_shifted = PROD_W'(pp_ff);
         SH_HALF: pp_shifted = PROD_W'({pp_ff, {HALF_W{1'b0}}});
         default: pp_shifted = {pp_ff[PROD_W-2*HALF_W-1:0], {(2*HALF_W){1'b0}}};
      endcase
   end

   // square root step, two product bits a cycle
   always_comb begin
      sq_rem_in = {sq_rem_ff, prod_ff[PROD_W-1:PROD_W-2]};
      sq_trial  = (REM_W+2)'({root_ff, 2'b01});
      sq_take   = (sq_rem_in >= sq_trial);
   end

   // norm product accumulates here, then shifts out into the root unit
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         prod_ff   <= '0;
         sq_rem_ff <= '0;
         root_ff   <= '0;
      end else if (cmd.mul_add) begin
         prod_ff <= prod_ff + pp_shifted;
      end else if (cmd.sqrt_step) begin
         prod_ff   <= {prod_ff[PROD_W-3:0], 2'b00};
         sq_rem_ff <= sq_take ? REM_W'(sq_rem_in - sq_trial) : sq_rem_in[REM_W-1:0];
         root_ff   <= {root_ff[ROOT_W-2:0], sq_take};
      end
   end

   // divide with rounding: (2*|dot|*2^15 + r) / (2*r), one quotient bit a cycle
   assign mag      = dot_fin_ff[DOT_W-1] ? (~dot_fin_ff + 1'b1) : dot_fin_ff;
   assign div_take = (div_rem_ff >= dsh_ff);

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         div_rem_ff <= DIV_W'({mag, 16'b0}) + DIV_W'(root_ff);
         dsh_ff     <= DIV_W'({root_ff, {Q_W{1'b0}}});
         q_ff       <= '0;
      end else if (cmd.div_step) begin
         if (div_take) begin
            div_rem_ff <= div_rem_ff - dsh_ff;
         end
         dsh_ff <= {1'b0, dsh_ff[DIV_W-1:1]};
         q_ff   <= {q_ff[Q_W-2:0], div_take};
      end
   end

   // sign and saturation
   always_comb begin
      status_in = 1'b0;
      if (zero_ff) begin
         sim_in    = '0;
         status_in = 1'b1;
      end else if (dot_fin_ff[DOT_W-1]) begin
         sim_in = (q_ff > Q_W'(32768)) ? 16'sh8000 : $signed(16'd0 - q_ff[15:0]);
      end else begin
         sim_in = (q_ff > Q_W'(32767)) ? 16'sh7fff : $signed(q_ff[15:0]);
      end
   end

   // output beat payload
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         sim_ff    <= sim_in;
         status_ff <= status_in;
      end
   end

   assign similarity = sim_ff;
   assign status     = status_ff;

endmodule

`default_nettype wire

// ===== src/cosine_similarity_engine_top.sv =====
// top level of the cosine similarity engine
//
//   channel  dir  handshake      payload
//   req_if   in   valid/ready    u_elem, v_elem, last_elem
//   rsp_if   out  valid/ready    similarity, status
//   csr_if   in   valid/ready    wdata (quantized_mode), always ready
//
// one element pair a cycle while accumulating; the multiply-accumulate is two stages
// after the last pair req_if.ready stays low through capture, norm product (four 22x22
// partial products), square root (one root bit a cycle), divide (one quotient bit a cycle)
// and output; a zero norm skips to output
// a result waits in the output register; a stalled rsp_if holds the next result
// synchronous active-high reset clears accumulators, mode register and control state
`default_nettype none

module cosine_similarity_engine_top (
   input  wire logic  clock,
   input  wire logic  reset,
   cse_req_chan.sink  req_if,
   cse_rsp_chan.source rsp_if,
   cse_csr_chan.sink  csr_if
);

   cse_pkg::cse_cmd_type cmd;
   cse_pkg::cse_sts_type sts;

   // mode register takes a write in any cycle
   assign csr_if.ready = 1'b1;

   cse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_last  (req_if.last_elem),
      .req_ready (req_if.ready),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .csr_valid (csr_if.valid),
      .sts       (sts),
      .cmd       (cmd)
   );

   cse_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .u_elem     (req_if.u_elem),
      .v_elem     (req_if.v_elem),
      .csr_wdata  (csr_if.wdata),
      .cmd        (cmd),
      .sts        (sts),
      .similarity (rsp_if.similarity),
      .status     (rsp_if.status)
   );

endmodule

`default_nettype wire

// ===== src/cse_checker.sv =====
// port-level checks on the cosine similarity engine, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module cse_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_valid,
   input wire logic                                req_ready,
   input wire logic                                req_last_elem,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_ready,
   input wire logic signed [cse_pkg::SIM_W-1:0]    rsp_similarity,
   input wire logic                                rsp_status
);

   // a result beat holds until taken
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_similarity))
   // no pair is taken in the cycle after the last pair
   `ASSERT_NEXT(a_last_blocks, clock, reset, req_valid && req_ready && req_last_elem, !req_ready)
   // a zero norm always gives zero similarity
   `ASSERT_IMPL(a_zero_norm, clock, reset, rsp_valid && rsp_status, rsp_similarity == '0)

endmodule

bind cosine_similarity_engine_top cse_checker u_cse_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_if.valid),
   .req_ready      (req_if.ready),
   .req_last_elem  (req_if.last_elem),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_similarity (rsp_if.similarity),
   .rsp_status     (rsp_if.status)
);

`default_nettype wire
